// ===== rtl/stereo_feedback_delay_line_top_assert.svh =====
// assertion macros for the stereo feedback delay line
// no dependencies; taken in by the top level
`ifndef STEREO_FEEDBACK_DELAY_LINE_TOP_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_LINE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SFDL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define SFDL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfdl_pkg.sv =====
// shared types and constants for the stereo feedback delay line
// no dependencies
package sfdl_pkg;

  // default sizing
  localparam int unsigned DEFAULT_STORE_DEPTH = 131072;
  localparam int unsigned DEFAULT_SAMPLE_BITS = 24;

  // register widths
  localparam int unsigned DELAY_WHOLE_BITS = 17;
  localparam int unsigned DELAY_FRAC_BITS  = 8;
  localparam int unsigned GAIN_BITS        = 15;
  localparam int unsigned CFG_DATA_BITS    = 17;
  localparam int unsigned CFG_IDX_BITS     = 2;

  // register reset values
  localparam logic [DELAY_WHOLE_BITS-1:0] DELAY_WHOLE_RST = 17'd24000;
  localparam logic [DELAY_FRAC_BITS-1:0]  DELAY_FRAC_RST  = 8'd0;
  localparam logic [GAIN_BITS-1:0]        GAIN_RST        = 15'd16384;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DELAY_WHOLE   = 2'd0,
    CFG_DELAY_FRAC    = 2'd1,
    CFG_FEEDBACK_GAIN = 2'd2
  } sfdl_cfg_e;

  // per-cycle control from the sequencer to each lane
  typedef struct packed {
    logic rd_en;    // read both neighbours, latch the input sample
    logic near_ok;  // near entry has been written since reset
    logic far_ok;   // far entry has been written since reset
    logic mix_en;   // interpolation product
    logic gain_en;  // feedback gain product
    logic wr_en;    // write the result back
  } sfdl_ctrl_t;

endpackage

// ===== rtl/sfdl_lane.sv =====
// one channel of the delay line: store, interpolation, gain, rounding, saturation
// depends on sfdl_pkg
module sfdl_lane #(
  parameter int unsigned STORE_DEPTH = 131072,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                   clk_i,
  input  sfdl_pkg::sfdl_ctrl_t                   ctrl_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]         near_addr_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]         far_addr_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]         wr_addr_i,
  input  logic [sfdl_pkg::DELAY_FRAC_BITS-1:0]   frac_i,
  input  logic [sfdl_pkg::GAIN_BITS-1:0]         gain_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  output logic signed [SAMPLE_BITS-1:0]          result_o
);
  import sfdl_pkg::*;

  localparam int unsigned WGT_BITS  = DELAY_FRAC_BITS + 2;          // signed weight 0..256
  localparam int unsigned T_BITS    = SAMPLE_BITS + DELAY_FRAC_BITS + 1;
  localparam int unsigned P_BITS    = T_BITS + GAIN_BITS + 1;
  localparam int unsigned D_BITS    = P_BITS - 23;
  localparam int unsigned S_BITS    = SAMPLE_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] in_q, near_q, far_q;
  logic                          near_ok_q, far_ok_q;
  logic signed [T_BITS-1:0]      t_q;
  logic signed [P_BITS-1:0]      p_q;

  logic signed [SAMPLE_BITS-1:0] near_s, far_s;
  logic signed [WGT_BITS-1:0]    w_near, w_far;
  logic signed [T_BITS-1:0]      t_d;
  logic signed [P_BITS-1:0]      p_d, rnd;
  logic signed [D_BITS-1:0]      dly;
  logic signed [S_BITS-1:0]      sum;
  logic [S_BITS-SAMPLE_BITS:0]   top_bits;

  // delay store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= result_o;
    end
    if (ctrl_i.rd_en) begin
      near_q    <= mem_q[near_addr_i];
      far_q     <= mem_q[far_addr_i];
      near_ok_q <= ctrl_i.near_ok;
      far_ok_q  <= ctrl_i.far_ok;
      in_q      <= sample_i;
    end
  end

  // entries never written since reset read as zero
  assign near_s = near_ok_q ? near_q : '0;
  assign far_s  = far_ok_q  ? far_q  : '0;

  // linear interpolation between the two neighbours
  assign w_far  = $signed({2'b00, frac_i});
  assign w_near = $signed(WGT_BITS'(1 << DELAY_FRAC_BITS)) - w_far;
  assign t_d    = (T_BITS'(near_s) * T_BITS'(w_near)) + (T_BITS'(far_s) * T_BITS'(w_far));

  // feedback gain
  assign p_d = P_BITS'(t_q) * P_BITS'($signed({1'b0, gain_i}));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mix_en) begin
      t_q <= t_d;
    end
    if (ctrl_i.gain_en) begin
      p_q <= p_d;
    end
  end

  // round half up, add the input, saturate
  assign rnd      = p_q + $signed(P_BITS'(1 << 22));
  assign dly      = rnd[P_BITS-1:23];
  assign sum      = S_BITS'(in_q) + S_BITS'(dly);
  assign top_bits = sum[S_BITS-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result_o = sum[SAMPLE_BITS-1:0];
    end else if (sum[S_BITS-1]) begin
      result_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/sfdl_merge.sv =====
// output stage: joins both lane results into one result register
// depends on no other file
module sfdl_merge #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;

  // room when empty or when the held result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

  assign out_valid_o = valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

// ===== rtl/stereo_feedback_delay_line_top.sv =====
// top level of the stereo feedback delay line: registers, sequencer, two lanes
// depends on sfdl_pkg, sfdl_lane, sfdl_merge, stereo_feedback_delay_line_top_assert.svh
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o    | left_in_i, right_in_i
//  out     | output    | out_valid_o / out_stall_i  | left_out_o, right_out_o
//  cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// a frame goes through these steps in order: the accepting edge reads both neighbouring
// entries of each store over two read ports, then interpolation product, gain product,
// and saturation with write-back; the two channels run in parallel lanes.
// no clearing pass after reset: a fill mark (write index plus a wrap flag) makes
// entries not yet written read as zero. the write-back cycle waits while the result
// register is full and stalled; the depth must be a power of two.
`include "stereo_feedback_delay_line_top_assert.svh"

module stereo_feedback_delay_line_top #(
  parameter int unsigned STORE_DEPTH = sfdl_pkg::DEFAULT_STORE_DEPTH,
  parameter int unsigned SAMPLE_BITS = sfdl_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]       right_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       left_out_o,
  output logic signed [SAMPLE_BITS-1:0]       right_out_o,
  input  logic                                cfg_we_i,
  input  logic [sfdl_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sfdl_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import sfdl_pkg::*;

  localparam int unsigned ADDR_BITS = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_GAIN,
    S_SUM
  } state_e;

  state_e                       state_q;
  logic [ADDR_BITS-1:0]         wr_idx_q;
  logic                         wrapped_q;
  logic [DELAY_WHOLE_BITS-1:0]  delay_whole_q;
  logic [DELAY_FRAC_BITS-1:0]   delay_frac_q;
  logic [GAIN_BITS-1:0]         gain_q;

  logic                          accept;
  logic                          out_free;
  logic [ADDR_BITS-1:0]          near_addr, far_addr;
  sfdl_ctrl_t                    ctrl;
  logic signed [SAMPLE_BITS-1:0] left_res, right_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_whole_q <= DELAY_WHOLE_RST;
      delay_frac_q  <= DELAY_FRAC_RST;
      gain_q        <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (sfdl_cfg_e'(cfg_idx_i))
        CFG_DELAY_WHOLE:   delay_whole_q <= DELAY_WHOLE_BITS'(cfg_data_i);
        CFG_DELAY_FRAC:    delay_frac_q  <= DELAY_FRAC_BITS'(cfg_data_i);
        CFG_FEEDBACK_GAIN: gain_q        <= GAIN_BITS'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // request handshake and read addresses
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign near_addr  = wr_idx_q - ADDR_BITS'(delay_whole_q);
  assign far_addr   = near_addr - 1'b1;

  // lane control
  always_comb begin
    ctrl.rd_en   = accept;
    ctrl.near_ok = wrapped_q || (near_addr < wr_idx_q);
    ctrl.far_ok  = wrapped_q || (far_addr < wr_idx_q);
    ctrl.mix_en  = (state_q == S_MIX);
    ctrl.gain_en = (state_q == S_GAIN);
    ctrl.wr_en   = (state_q == S_SUM) && out_free;
  end

  // sequencer, write index and fill mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wr_idx_q  <= '0;
      wrapped_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_MIX;
          end
        end
        S_MIX:  state_q <= S_GAIN;
        S_GAIN: state_q <= S_SUM;
        S_SUM: begin
          if (out_free) begin
            state_q  <= S_IDLE;
            wr_idx_q <= wr_idx_q + 1'b1;
            if (&wr_idx_q) begin
              wrapped_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // left and right lanes
  sfdl_lane #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .near_addr_i (near_addr),
    .far_addr_i  (far_addr),
    .wr_addr_i   (wr_idx_q),
    .frac_i      (delay_frac_q),
    .gain_i      (gain_q),
    .sample_i    (left_in_i),
    .result_o    (left_res)
  );

  sfdl_lane #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .near_addr_i (near_addr),
    .far_addr_i  (far_addr),
    .wr_addr_i   (wr_idx_q),
    .frac_i      (delay_frac_q),
    .gain_i      (gain_q),
    .sample_i    (right_in_i),
    .result_o    (right_res)
  );

  // result register
  sfdl_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (state_q == S_SUM),
    .left_i      (left_res),
    .right_i     (right_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  // checks
  `SFDL_ASSERT_NEXT(accept_to_mix_a, clk_i, rst_ni, accept, state_q == S_MIX, "accepted request did not start the interpolation step")
  `SFDL_ASSERT_NEXT(wr_idx_step_a, clk_i, rst_ni, ctrl.wr_en, wr_idx_q == ADDR_BITS'($past(wr_idx_q) + 1'b1), "write index did not advance by one after a write")
  `SFDL_ASSERT_NEXT(wrapped_holds_a, clk_i, rst_ni, wrapped_q, wrapped_q, "fill mark cleared without reset")
  `SFDL_ASSERT_NOW(out_from_sum_a, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == S_SUM), "result appeared without a write-back step")

endmodule

// ===== bench/tb.sv =====
// self-checking bench for stereo_feedback_delay_line_top: a bit-exact echo predictor,
// a request driver with bursty timing and a result checker fed by a receiver that stalls
// depends on sfdl_pkg and stereo_feedback_delay_line_top
module tb;
  import sfdl_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_STORE_DEPTH;
  localparam int unsigned SBITS = DEFAULT_SAMPLE_BITS;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef logic signed [SBITS-1:0] sample_t;
  typedef struct {
    sample_t left;
    sample_t right;
  } frame_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SBITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SBITS-1){1'b0}}};

  // block ports
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  sample_t                  left_in_i   = '0;
  sample_t                  right_in_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  sample_t                  left_out_o;
  sample_t                  right_out_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  // predictor state: echo stores, write position and register copies
  bit signed [SBITS-1:0]       echo_left  [DEPTH];
  bit signed [SBITS-1:0]       echo_right [DEPTH];
  int unsigned                 wr_pos     = 0;
  logic [DELAY_WHOLE_BITS-1:0] dly_whole  = DELAY_WHOLE_RST;
  logic [DELAY_FRAC_BITS-1:0]  dly_frac   = DELAY_FRAC_RST;
  logic [GAIN_BITS-1:0]        fb_gain    = GAIN_RST;

  // outputs still owed by the block, oldest first
  frame_t      echo_due [$];
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;

  // request and receiver timing controls
  int          burst_left = 0;
  int          gap_max    = 6;
  int          stall_pct  = 30;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;

  stereo_feedback_delay_line_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // interpolate, scale by the feedback gain, round half up and saturate
  function automatic sample_t mix_channel(sample_t near_s, sample_t far_s, sample_t in_s);
    longint t;
    longint p;
    longint d;
    longint s;
    t = longint'(near_s) * (256 - longint'(dly_frac)) + longint'(far_s) * longint'(dly_frac);
    p = t * longint'(fb_gain);
    d = (p + 64'sd4194304) >>> 23;
    s = longint'(in_s) + d;
    if (s > longint'(SAMPLE_MAX)) s = longint'(SAMPLE_MAX);
    if (s < longint'(SAMPLE_MIN)) s = longint'(SAMPLE_MIN);
    return sample_t'(s);
  endfunction

  // one stereo frame through the delay line, updating the stores
  function automatic frame_t predict_echo(frame_t req);
    int unsigned near_idx;
    int unsigned far_idx;
    frame_t      res;
    near_idx = (wr_pos + DEPTH - (int'(dly_whole) % DEPTH)) % DEPTH;
    far_idx  = (near_idx + DEPTH - 1) % DEPTH;
    res.left  = mix_channel(echo_left[near_idx], echo_left[far_idx], req.left);
    res.right = mix_channel(echo_right[near_idx], echo_right[far_idx], req.right);
    echo_left[wr_pos]  = res.left;
    echo_right[wr_pos] = res.right;
    wr_pos = (wr_pos + 1) % DEPTH;
    return res;
  endfunction

  // biased sample source: extremes, values near zero, full range
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // register write, mirrored into the predictor; only called while idle
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DELAY_WHOLE:   dly_whole = val[DELAY_WHOLE_BITS-1:0];
      CFG_DELAY_FRAC:    dly_frac  = val[DELAY_FRAC_BITS-1:0];
      CFG_FEEDBACK_GAIN: fb_gain   = val[GAIN_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one request, in bursts with random gaps, and log what it should produce
  task automatic send_frame(sample_t l, sample_t r);
    int     gap;
    frame_t req;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    req.left  = l;
    req.right = r;
    echo_due.push_back(predict_echo(req));
  endtask

  // drop valid and wait until every owed output has come back
  task automatic end_phase();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (echo_due.size() != 0) @(posedge clk_i);
  endtask

  // default registers: long delay reads only entries not yet written
  task automatic test_reset_state();
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame('0, -1);
    send_frame(-1, '0);
    end_phase();
  endtask

  // one-sample delay with gain at its maximum, just under one, drives the sum into the rails
  task automatic test_saturation();
    write_reg(CFG_DELAY_WHOLE, 17'd1);
    write_reg(CFG_DELAY_FRAC, 17'd0);
    write_reg(CFG_FEEDBACK_GAIN, 17'd32767);
    repeat (3) send_frame(SAMPLE_MAX, SAMPLE_MIN);
    repeat (2) send_frame(SAMPLE_MIN, SAMPLE_MAX);
    end_phase();
  endtask

  // interpolation between neighbours at the top fraction and at one half
  task automatic test_fractional_read();
    write_reg(CFG_DELAY_WHOLE, 17'd2);
    write_reg(CFG_DELAY_FRAC, 17'd255);
    write_reg(CFG_FEEDBACK_GAIN, 17'd32440);
    send_frame(24'sd1000000, -24'sd3000000);
    send_frame(-24'sd777777, 24'sd4000000);
    send_frame(24'sd12345, -24'sd1);
    end_phase();
    write_reg(CFG_DELAY_FRAC, 17'd128);
    send_frame(24'sd3, -24'sd5);
    send_frame(-24'sd2000000, 24'sd2500000);
    end_phase();
  endtask

  // zero delay reads the slot about to be written; a fraction pulls in the last sample
  task automatic test_zero_delay();
    write_reg(CFG_DELAY_WHOLE, 17'd0);
    write_reg(CFG_DELAY_FRAC, 17'd0);
    write_reg(CFG_FEEDBACK_GAIN, 17'd20000);
    send_frame(24'sd500000, -24'sd600000);
    send_frame(-24'sd700000, 24'sd800000);
    end_phase();
    write_reg(CFG_DELAY_FRAC, 17'd77);
    send_frame(24'sd100, -24'sd100);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    end_phase();
  endtask

  // oversized write data is cut to the register width, the spare index does nothing
  task automatic test_register_masking();
    write_reg(CFG_DELAY_FRAC, 17'h1FFFF);
    write_reg(CFG_FEEDBACK_GAIN, 17'h1FFFF);
    write_reg(CFG_DELAY_WHOLE, 17'h1FFFF);
    write_reg(CFG_SPARE, 17'h00005);
    send_frame(24'sd4096, -24'sd4096);
    send_frame(-24'sd1, 24'sd1);
    end_phase();
    write_reg(CFG_DELAY_WHOLE, 17'd131070);
    send_frame(24'sd654321, -24'sd123456);
    end_phase();
  endtask

  // random registers, mostly short delays so that the feedback path carries data
  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] whole;
    logic [CFG_DATA_BITS-1:0] frac;
    logic [CFG_DATA_BITS-1:0] gain;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: whole = 17'd0;
          1: whole = 17'd1;
          2: whole = 17'd131070;
          default: whole = 17'd131071;
        endcase
      end
      1, 2: whole = CFG_DATA_BITS'($urandom_range(1, 600));
      default: whole = CFG_DATA_BITS'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 5))
      0: frac = 17'd0;
      1: frac = 17'd255;
      default: frac = CFG_DATA_BITS'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0: gain = 17'd0;
      1: gain = 17'd32767;
      2: gain = 17'd32440;
      default: gain = CFG_DATA_BITS'($urandom_range(0, 32767));
    endcase
    write_reg(CFG_DELAY_WHOLE, whole);
    write_reg(CFG_DELAY_FRAC, frac);
    write_reg(CFG_FEEDBACK_GAIN, gain);
  endtask

  // phases of random frames under changing registers and timing
  task automatic test_random_traffic();
    int phase;
    int k;
    for (phase = 0; phase < 6; phase++) begin
      random_config();
      case (phase)
        0: begin stall_pct = 0;  gap_max = 0;  end
        1: begin stall_pct = 25; gap_max = 8;  end
        2: begin stall_pct = 60; gap_max = 3;  end
        3: begin stall_pct = 85; gap_max = 12; end
        4: begin stall_pct = 10; gap_max = 0;  end
        default: begin stall_pct = 40; gap_max = 20; end
      endcase
      for (k = 0; k < 70; k++) send_frame(rand_sample(), rand_sample());
      end_phase();
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_input_backpressure();
    int k;
    write_reg(CFG_DELAY_WHOLE, 17'd3);
    write_reg(CFG_DELAY_FRAC, 17'd64);
    write_reg(CFG_FEEDBACK_GAIN, 17'd30000);
    stall_pct = 20;
    gap_max   = 0;
    hold_req  = 1'b1;
    for (k = 0; k < 40; k++) send_frame(rand_sample(), rand_sample());
    end_phase();
  endtask

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // compare each delivered frame with the oldest owed one
  always @(posedge clk_i) begin
    frame_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (echo_due.size() == 0) begin
        errors++;
        $display("%0t unexpected output: left %0d right %0d", $time, left_out_o, right_out_o);
      end else begin
        due = echo_due.pop_front();
        if (left_out_o !== due.left) begin
          errors++;
          $display("%0t left_out: expected %0d actual %0d", $time, due.left, left_out_o);
        end
        if (right_out_o !== due.right) begin
          errors++;
          $display("%0t right_out: expected %0d actual %0d", $time, due.right, right_out_o);
        end
      end
    end
  end

  // watchdog on cycles with no request or output moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("status: fail");
      $finish;
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_saturation();
    test_fractional_read();
    test_zero_delay();
    test_register_masking();
    test_input_backpressure();
    test_random_traffic();
    end_phase();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
